@@ hdl/smvc_pkg.sv @@
// Shared types, op codes and a helper function for the sign-magnitude converter.
package smvc_pkg;

    typedef enum logic [1:0] {
        OP_DEC_FIX = 2'd0,
        OP_ENC_FIX = 2'd1,
        OP_DEC_INT = 2'd2,
        OP_ENC_INT = 2'd3
    } op_t;

    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_8    = 8'h38;

    // Decoded request after the first stage.
    typedef struct packed {
        op_t         op;
        logic        fmt_ok;    // type and size valid
        logic        sgn;
        logic [3:0]  fbits;     // fraction bits for fixed formats
        logic [5:0]  ibits;     // 8/16/32 for integer formats
        logic [31:0] raw;
        logic [31:0] val;
    } dec_t;

    // Hex digit value (0-9, lower-case a-f); anything else counts zero.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c > 8'd96 && c < 8'd103) d = 5'(c - 8'd87);
        else if (c > 8'd47 && c < 8'd58) d = 5'(c - 8'd48);
        return d;
    endfunction

endpackage

@@ hdl/smvc_decode.sv @@
// Stage 1: type code and size check.
module smvc_decode (
    input  logic        aclk,
    input  logic        en,
    input  logic [1:0]  op,
    input  logic [31:0] type_code,
    input  logic [5:0]  byte_count,
    input  logic [31:0] raw_in,
    input  logic [31:0] value_in,
    output smvc_pkg::dec_t dec_reg
);
    logic [7:0] c0, c1, c2, c3;
    logic [4:0] ib, fb;
    logic       len_ok, sgn, fix_ok, int_fmt;
    smvc_pkg::dec_t dec_next;

    assign c0 = type_code[31:24];
    assign c1 = type_code[23:16];
    assign c2 = type_code[15:8];
    assign c3 = type_code[7:0];

    always_comb begin
        len_ok  = (c0 != 8'd0) && (c1 != 8'd0) && (c2 != 8'd0);
        sgn     = (c0 == smvc_pkg::CH_S);
        ib      = smvc_pkg::digit_value(c2);
        fb      = smvc_pkg::digit_value(c3);
        fix_ok  = len_ok && (c0 == smvc_pkg::CH_F || sgn) && c1 == smvc_pkg::CH_P
                  && ({1'b0, ib} + {1'b0, fb} == (sgn ? 6'd15 : 6'd16));
        int_fmt = len_ok && (c0 == smvc_pkg::CH_U || sgn) && c1 == smvc_pkg::CH_I;
        dec_next.op    = smvc_pkg::op_t'(op);
        dec_next.sgn   = sgn;
        dec_next.fbits = fb[3:0];
        dec_next.ibits = 6'd0;
        dec_next.raw   = raw_in;
        dec_next.val   = value_in;
        dec_next.fmt_ok = 1'b0;
        case (smvc_pkg::op_t'(op))
            smvc_pkg::OP_DEC_FIX: dec_next.fmt_ok = fix_ok && byte_count == 6'd2;
            smvc_pkg::OP_ENC_FIX: dec_next.fmt_ok = fix_ok;
            default: begin
                if (int_fmt) begin
                    if (c2 == smvc_pkg::CH_8 && byte_count == 6'd1
                        && (op == smvc_pkg::OP_DEC_INT || c3 == 8'd0))
                        dec_next.ibits = 6'd8;
                    else if (c2 == smvc_pkg::CH_1 && c3 == smvc_pkg::CH_6
                             && byte_count == 6'd2)
                        dec_next.ibits = 6'd16;
                    else if (c2 == smvc_pkg::CH_3 && c3 == smvc_pkg::CH_2
                             && byte_count == 6'd4)
                        dec_next.ibits = 6'd32;
                end
                dec_next.fmt_ok = dec_next.ibits != 6'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) dec_reg <= dec_next;
    end
endmodule

@@ hdl/smvc_fix_float.sv @@
// Fixed-point <-> float arithmetic, two register stages.
module smvc_fix_float (
    input  logic        aclk,
    input  logic        en1,
    input  logic        en2,
    input  smvc_pkg::dec_t d,
    output logic [31:0] fdec_reg,   // float bits from a fixed decode
    output logic [15:0] fenc_reg    // fixed word from a float encode
);
    // ---- stage A: decode normalization (count leading zeros) and encode prep
    logic [14:0] w;
    logic        dneg;
    logic [15:0] mag;
    logic [4:0]  lz;
    logic [15:0] mag_reg;
    logic [4:0]  lz_reg;
    logic        dneg_reg;
    logic [3:0]  fb_reg;
    // encode
    logic [7:0]  ex;
    logic [22:0] fr;
    logic        eneg, nan, inf;
    logic signed [9:0] sh;          // unbiased exponent + F
    logic [23:0] mant;
    logic [15:0] enc_mag;
    logic [15:0] encw_reg;

    always_comb begin
        w    = d.raw[14:0];
        dneg = d.sgn && d.raw[15];
        mag  = dneg ? {1'b0, w} : d.raw[15:0];
        lz   = 5'd16;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) lz = 5'(15 - i);
        end
        ex   = d.val[30:23];
        fr   = d.val[22:0];
        nan  = (ex == 8'hFF) && (fr != 23'd0);
        inf  = (ex == 8'hFF) && (fr == 23'd0);
        eneg = d.val[31] && !nan && (d.val[30:0] != 31'd0);
        mant = {1'b1, fr};
        sh   = $signed({2'b0, ex}) - 10'sd127 + $signed({6'd0, d.fbits});
        if (nan || ex == 8'd0) enc_mag = 16'd0;
        else if (inf || sh >= 10'sd16) enc_mag = 16'hFFFF;
        else if (sh < 10'sd0) enc_mag = 16'd0;
        else enc_mag = 16'(mant >> (5'd23 - 5'(sh)));
        if (d.sgn) enc_mag = {eneg, enc_mag[14:0]};
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mag_reg  <= mag;
            lz_reg   <= lz;
            dneg_reg <= dneg;
            fb_reg   <= d.fbits;
            encw_reg <= enc_mag;
        end
    end

    // ---- stage B: assemble float from normalized magnitude
    logic [15:0] nm;
    logic [7:0]  fexp;
    logic [31:0] fbits;
    always_comb begin
        nm    = mag_reg << lz_reg[3:0];
        fexp  = 8'(8'd142 - {3'd0, lz_reg} - {4'd0, fb_reg});
        if (lz_reg == 5'd16) fbits = {dneg_reg, 31'd0};
        else fbits = {dneg_reg, fexp, nm[14:0], 8'd0};
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            fdec_reg <= fbits;
            fenc_reg <= encw_reg;
        end
    end
endmodule

@@ hdl/smvc_int.sv @@
// Integer encode/decode, two register stages.
module smvc_int (
    input  logic        aclk,
    input  logic        en1,
    input  logic        en2,
    input  smvc_pkg::dec_t d,
    output logic [31:0] idec_reg,
    output logic [31:0] ienc_reg
);
    logic [31:0] mask, top, e, mag, ee;
    logic        neg, dn;
    logic [31:0] de_reg, ee_reg;
    logic        dn_reg;

    always_comb begin
        case (d.ibits)
            6'd8:    begin mask = 32'hFF;   top = 32'h80; end
            6'd16:   begin mask = 32'hFFFF; top = 32'h8000; end
            default: begin mask = 32'hFFFFFFFF; top = 32'h80000000; end
        endcase
        e   = d.raw & mask;
        dn  = d.sgn && ((e & top) != 32'd0);
        if (dn) e = e & ~top;
        neg = d.val[31];
        mag = neg ? (32'd0 - d.val) : d.val;
        ee  = mag & mask;
        if (d.sgn) ee = (ee & ~top) | (neg ? top : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            de_reg <= e;
            dn_reg <= dn;
            ee_reg <= ee;
        end
        if (en2) begin
            idec_reg <= dn_reg ? (32'd0 - de_reg) : de_reg;
            ienc_reg <= ee_reg;
        end
    end
endmodule

@@ hdl/sign_magnitude_value_converter.sv @@
// Top level: sign-magnitude value converter, four-stage pipeline.
// Path: an accepted item passes the decode, arith A, arith B and out registers in turn.
// Throughput: one item per cycle; the set of stage registers advances whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Reset: aresetn synchronous active low clears all stage valid bits; data regs are not reset.
module sign_magnitude_value_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_type_code,
    input  logic [5:0]  s_byte_count,
    input  logic [31:0] s_raw_in,
    input  logic signed [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_raw_out,
    output logic signed [31:0] m_value_out
);
    // global advance: whole pipe moves together when output can take an item
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    assign adv     = !v4_reg || m_ready;
    assign s_ready = adv;

    smvc_pkg::dec_t d1_reg;
    smvc_decode u_dec (
        .aclk(aclk), .en(adv), .op(s_op), .type_code(s_type_code),
        .byte_count(s_byte_count), .raw_in(s_raw_in), .value_in(s_value_in),
        .dec_reg(d1_reg)
    );

    logic [31:0] fdec, idec, ienc;
    logic [15:0] fenc;
    smvc_fix_float u_ff (
        .aclk(aclk), .en1(adv), .en2(adv), .d(d1_reg),
        .fdec_reg(fdec), .fenc_reg(fenc)
    );
    smvc_int u_int (
        .aclk(aclk), .en1(adv), .en2(adv), .d(d1_reg),
        .idec_reg(idec), .ienc_reg(ienc)
    );

    // op/ok travel alongside the arithmetic stages
    smvc_pkg::op_t op2_reg, op3_reg;
    logic          ok2_reg, ok3_reg;
    logic          ok4_reg;
    logic [31:0]   raw4_reg, val4_reg;
    logic [31:0]   raw4_next, val4_next;

    // pick the field the op writes; a rejected item carries zeros
    always_comb begin
        raw4_next = 32'd0;
        val4_next = 32'd0;
        if (ok3_reg) begin
            case (op3_reg)
                smvc_pkg::OP_DEC_FIX: val4_next = fdec;
                smvc_pkg::OP_ENC_FIX: raw4_next = {16'd0, fenc};
                smvc_pkg::OP_DEC_INT: val4_next = idec;
                smvc_pkg::OP_ENC_INT: raw4_next = ienc;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op2_reg <= d1_reg.op;
            ok2_reg <= d1_reg.fmt_ok;
            op3_reg <= op2_reg;
            ok3_reg <= ok2_reg;
            ok4_reg <= ok3_reg;
            raw4_reg <= raw4_next;
            val4_reg <= val4_next;
        end
    end

    always_comb begin
        v1_next = adv ? s_valid : v1_reg;
        v2_next = adv ? v1_reg  : v2_reg;
        v3_next = adv ? v2_reg  : v3_reg;
        v4_next = adv ? v3_reg  : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign m_valid     = v4_reg;
    assign m_ok        = ok4_reg;
    assign m_raw_out   = raw4_reg;
    assign m_value_out = val4_reg;

    // a result that is not ok carries zero data
    a_zero_when_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_raw_out == 32'd0 && m_value_out == 32'd0))
        else $error("non-ok item with data");
    // a decode never writes raw_out, an encode never writes value_out
    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_raw_out == 32'd0 || m_value_out == 32'd0))
        else $error("both data fields set");
    // a stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_raw_out) && $stable(m_value_out)))
        else $error("output changed under stall");
endmodule
